// ===== hw/rtl/cbfnm_pkg.sv =====
`timescale 1ns / 1ps

package cbfnm_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);

  localparam int POS_W  = 12;
  localparam int SIZE_W = 13;
  localparam int END_W  = 14;
  localparam int PIX_W  = 25;
  localparam int AREA_W = 2 * SIZE_W;
  localparam int CFG_W  = 25;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PIX  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA = 1'b1;

  localparam logic [CFG_W-1:0]  RST_MIN_PIX  = 25'd60;
  localparam logic [CFG_W-1:0]  RST_MIN_AREA = 25'd200;
  localparam logic [SIZE_W-1:0] SIZE_MAX     = 13'h1FFF;

  typedef struct packed {
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  top;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              color;
  } box_t;

  // controller to datapath
  typedef struct packed {
    logic             load_item;
    logic             store_item;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    logic             load_a;
    logic             cmp_en;
    logic [IDX_W-1:0] cmp_idx;
    logic             emit;
    logic             finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             frame_last;
    logic             probe_alive;
  } sts_t;

endpackage

// ===== hw/rtl/cbfnm_ctrl.sv =====
`timescale 1ns / 1ps

module cbfnm_ctrl import cbfnm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILT  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_INNER = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_ENDF  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = j_q[IDX_W-1:0];

    cmd_o            = '0;
    cmd_o.addr       = (state_q == ST_SCAN) ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
    cmd_o.cmp_en     = cmp_vld_q;
    cmd_o.cmp_idx    = cmp_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_FILT;
        end
      end
      ST_FILT: begin
        cmd_o.store_item = 1'b1;
        if (sts_i.frame_last) begin
          i_d     = '0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // walk to the next live box that opens a merge round
        if (i_q == sts_i.count) begin
          state_d = ST_ENDF;
        end else if (sts_i.probe_alive) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_LOAD;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_LOAD: begin
        cmd_o.load_a = 1'b1;
        j_d          = i_q + 1'b1;
        state_d      = ST_INNER;
      end
      ST_INNER: begin
        // read box j now, test it against the held box next cycle
        if (j_q == sts_i.count) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmp_vld_d   = sts_i.probe_alive;
          j_d         = j_q + 1'b1;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        i_d        = i_q + 1'b1;
        state_d    = ST_SCAN;
      end
      ST_ENDF: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
    end
  end

endmodule

// ===== hw/rtl/cbfnm_dpath.sv =====
`timescale 1ns / 1ps

module cbfnm_dpath import cbfnm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [POS_W-1:0]     box_left_i,
  input  logic [POS_W-1:0]     box_top_i,
  input  logic [SIZE_W-1:0]    box_width_i,
  input  logic [SIZE_W-1:0]    box_height_i,
  input  logic [PIX_W-1:0]     pixel_count_i,
  input  logic                 color_i,
  input  logic                 frame_last_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 res_strobe_o,
  output logic [POS_W-1:0]     out_left_o,
  output logic [POS_W-1:0]     out_top_o,
  output logic [SIZE_W-1:0]    out_width_o,
  output logic [SIZE_W-1:0]    out_height_o,
  output logic                 out_color_o,
  output logic                 valid_res_o,
  output logic                 overflow_o,
  output logic                 last_o
);

  logic [CFG_W-1:0] min_pix_q, min_area_q;

  box_t             item_q;
  logic [PIX_W-1:0] item_pix_q;
  logic             item_last_q;

  box_t             mem_q [MAX_BOXES];
  box_t             rd_q;
  logic [MAX_BOXES-1:0] alive_q;
  logic [CNT_W-1:0] count_q;
  logic             ovf_q;

  box_t             a_q;
  box_t             pend_q;
  logic             pend_vld_q;

  box_t             out_q;
  logic             out_stb_q, out_valid_q, out_ovf_q, out_last_q;

  logic [AREA_W-1:0] area;
  logic              keep;
  logic              full;

  logic [END_W-1:0]  ax2, ay2, bx2, by2;
  logic [POS_W-1:0]  ix1, iy1, ux1, uy1;
  logic [END_W-1:0]  ix2, iy2, ux2, uy2;
  logic [END_W-1:0]  iw, ih, uw, uh;
  logic              nest;
  box_t              uni;

  // ---------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pix_q  <= RST_MIN_PIX;
      min_area_q <= RST_MIN_AREA;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_PIX:  min_pix_q  <= cfg_wdata_i;
        CFG_MIN_AREA: min_area_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- filter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q.left   <= box_left_i;
      item_q.top    <= box_top_i;
      item_q.width  <= box_width_i;
      item_q.height <= box_height_i;
      item_q.color  <= color_i;
      item_pix_q    <= pixel_count_i;
      item_last_q   <= frame_last_i;
    end
  end

  assign area = item_q.width * item_q.height;
  assign keep = !((item_pix_q < min_pix_q) && (area < AREA_W'(min_area_q)));
  assign full = (count_q == CNT_W'(MAX_BOXES));

  // ---------------- nest test of held box A against box B
  assign ax2 = END_W'(a_q.left) + END_W'(a_q.width);
  assign ay2 = END_W'(a_q.top) + END_W'(a_q.height);
  assign bx2 = END_W'(rd_q.left) + END_W'(rd_q.width);
  assign by2 = END_W'(rd_q.top) + END_W'(rd_q.height);

  assign ix1 = (a_q.left > rd_q.left) ? a_q.left : rd_q.left;
  assign iy1 = (a_q.top > rd_q.top) ? a_q.top : rd_q.top;
  assign ix2 = (ax2 < bx2) ? ax2 : bx2;
  assign iy2 = (ay2 < by2) ? ay2 : by2;
  assign iw  = ix2 - END_W'(ix1);
  assign ih  = iy2 - END_W'(iy1);

  // intersection lies inside both boxes, so equal area means equal sides
  assign nest = (ix2 > END_W'(ix1)) && (iy2 > END_W'(iy1)) &&
                (((iw == END_W'(a_q.width)) && (ih == END_W'(a_q.height))) ||
                 ((iw == END_W'(rd_q.width)) && (ih == END_W'(rd_q.height))));

  assign ux1 = (a_q.left < rd_q.left) ? a_q.left : rd_q.left;
  assign uy1 = (a_q.top < rd_q.top) ? a_q.top : rd_q.top;
  assign ux2 = (ax2 > bx2) ? ax2 : bx2;
  assign uy2 = (ay2 > by2) ? ay2 : by2;
  assign uw  = ux2 - END_W'(ux1);
  assign uh  = uy2 - END_W'(uy1);

  always_comb begin
    uni.left   = ux1;
    uni.top    = uy1;
    uni.width  = (uw > END_W'(SIZE_MAX)) ? SIZE_MAX : uw[SIZE_W-1:0];
    uni.height = (uh > END_W'(SIZE_MAX)) ? SIZE_MAX : uh[SIZE_W-1:0];
    uni.color  = rd_q.color;
  end

  // ---------------- box store
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_item && keep && !full) begin
      mem_q[count_q[IDX_W-1:0]] <= item_q;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.finish) begin
      alive_q <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.store_item && keep) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          alive_q[count_q[IDX_W-1:0]] <= 1'b1;
          count_q                     <= count_q + 1'b1;
        end
      end
      if (cmd_i.cmp_en && nest) begin
        alive_q[cmd_i.cmp_idx] <= 1'b0;
      end
    end
  end

  // ---------------- held box and one-deep pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) begin
      a_q <= rd_q;
    end else if (cmd_i.cmp_en && nest) begin
      a_q <= uni;
    end
    if (cmd_i.emit) begin
      pend_q <= a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      pend_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      pend_vld_q <= 1'b1;
    end
  end

  // ---------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stb_q <= 1'b0;
    end else begin
      out_stb_q <= (cmd_i.emit && pend_vld_q) || cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q       <= pend_q;
      out_valid_q <= 1'b1;
      out_last_q  <= 1'b0;
      out_ovf_q   <= ovf_q;
    end else if (cmd_i.finish) begin
      out_q       <= pend_vld_q ? pend_q : '0;
      out_valid_q <= pend_vld_q;
      out_last_q  <= 1'b1;
      out_ovf_q   <= ovf_q;
    end
  end

  assign sts_o.count       = count_q;
  assign sts_o.frame_last  = item_last_q;
  assign sts_o.probe_alive = alive_q[cmd_i.addr];

  assign res_strobe_o = out_stb_q;
  assign out_left_o   = out_q.left;
  assign out_top_o    = out_q.top;
  assign out_width_o  = out_q.width;
  assign out_height_o = out_q.height;
  assign out_color_o  = out_q.color;
  assign valid_res_o  = out_valid_q;
  assign overflow_o   = out_ovf_q;
  assign last_o       = out_last_q;

endmodule

// ===== hw/rtl/component_box_filter_nest_merge.sv =====
`timescale 1ns / 1ps
// An item is taken from idle and filtered and stored in the next cycle, with busy high. On
// the frame's last item the merge runs over the store's single read port: it skips removed
// boxes, loads each live box, reads and tests each later box against it, and emits it;
// a finish step closes. A survivor's beat leaves in the cycle after the next survivor's
// round ends, the final beat in the first cycle with busy low. No result for other items.
// Reset sets thresholds 60 and 200 and empties the store; the receiver cannot stall beats.
module component_box_filter_nest_merge import cbfnm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [POS_W-1:0]     box_left_i,
  input  logic [POS_W-1:0]     box_top_i,
  input  logic [SIZE_W-1:0]    box_width_i,
  input  logic [SIZE_W-1:0]    box_height_i,
  input  logic [PIX_W-1:0]     pixel_count_i,
  input  logic                 color_i,
  input  logic                 frame_last_i,
  output logic                 res_strobe_o,
  output logic [POS_W-1:0]     out_left_o,
  output logic [POS_W-1:0]     out_top_o,
  output logic [SIZE_W-1:0]    out_width_o,
  output logic [SIZE_W-1:0]    out_height_o,
  output logic                 out_color_o,
  output logic                 valid_res_o,
  output logic                 overflow_o,
  output logic                 last_o
);

  cmd_t cmd;
  sts_t sts;

  cbfnm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cbfnm_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .box_left_i    (box_left_i),
    .box_top_i     (box_top_i),
    .box_width_i   (box_width_i),
    .box_height_i  (box_height_i),
    .pixel_count_i (pixel_count_i),
    .color_i       (color_i),
    .frame_last_i  (frame_last_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .res_strobe_o  (res_strobe_o),
    .out_left_o    (out_left_o),
    .out_top_o     (out_top_o),
    .out_width_o   (out_width_o),
    .out_height_o  (out_height_o),
    .out_color_o   (out_color_o),
    .valid_res_o   (valid_res_o),
    .overflow_o    (overflow_o),
    .last_o        (last_o)
  );

endmodule

// ===== hw/rtl/cbfnm_chk.sv =====
`timescale 1ns / 1ps

module cbfnm_chk import cbfnm_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [CFG_W-1:0]     cfg_wdata_i,
  input logic [POS_W-1:0]     box_left_i,
  input logic [POS_W-1:0]     box_top_i,
  input logic [SIZE_W-1:0]    box_width_i,
  input logic [SIZE_W-1:0]    box_height_i,
  input logic [PIX_W-1:0]     pixel_count_i,
  input logic                 color_i,
  input logic                 frame_last_i,
  input logic                 res_strobe_o,
  input logic [POS_W-1:0]     out_left_o,
  input logic [POS_W-1:0]     out_top_o,
  input logic [SIZE_W-1:0]    out_width_o,
  input logic [SIZE_W-1:0]    out_height_o,
  input logic                 out_color_o,
  input logic                 valid_res_o,
  input logic                 overflow_o,
  input logic                 last_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy))
    else $error("result beat without preceding work");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !valid_res_o) |-> last_o)
    else $error("empty-frame beat not marked last");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !valid_res_o) |-> (out_left_o == '0 && out_top_o == '0 &&
      out_width_o == '0 && out_height_o == '0 && !out_color_o))
    else $error("empty-frame beat carries box fields");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && last_o) |=> !res_strobe_o)
    else $error("result beat right after the frame's last");

endmodule

bind component_box_filter_nest_merge cbfnm_chk u_cbfnm_chk (.*);
